/* sv/cqr_pkg.sv */
// Shared types, codes and constants for the circular queue with replace.
package cqr_pkg;

    // Default ring depth
    localparam int DEPTH_DEF = 8;

    // Fixed field widths
    localparam int CMD_W    = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 3;
    localparam int IN_TDATA_W  = 72;  // 66 bits of fields, padded to whole bytes
    localparam int OUT_TDATA_W = 40;  // 37 bits of fields, padded to whole bytes

    // Commands carried by an input item
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POP     = 2'd1,
        CMD_REPLACE = 2'd2,
        CMD_DUMP    = 2'd3
    } command_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // Kind of result to load into the output register
    typedef enum logic [2:0] {
        EMIT_PUSH_OK  = 3'd0,
        EMIT_FULL     = 3'd1,
        EMIT_EMPTY    = 3'd2,
        EMIT_NOTFOUND = 3'd3,
        EMIT_POP      = 3'd4,
        EMIT_REPLACE  = 3'd5,
        EMIT_DUMP     = 3'd6
    } emit_t;

    // Captured input item
    typedef struct packed {
        command_t                  command;
        logic signed [WORD_W-1:0]  value;
        logic signed [WORD_W-1:0]  match_value;
    } item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic  load_item;
        logic  push_write;
        logic  pop_commit;
        logic  walk_start;
        logic  rd_issue;
        logic  walk_next;
        logic  repl_write;
        logic  emit;
        emit_t emit_sel;
    } dp_ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        command_t command;
        logic     empty;
        logic     full;
        logic     hit;
        logic     walk_last;
        logic     out_free;
    } dp_stat_t;

endpackage

/* sv/cqr_datapath.sv */
// Datapath: entry memory, ring indices, walk pointer and output register.
module cqr_datapath #(
    parameter int DEPTH = cqr_pkg::DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [cqr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [cqr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast,
    input  cqr_pkg::dp_ctrl_t                ctrl,
    output cqr_pkg::dp_stat_t                stat
);
    import cqr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic signed [WORD_W-1:0] mem [DEPTH];

    item_t                    item_reg;
    logic [AW-1:0]            front_reg, front_next;
    logic [AW-1:0]            rear_reg, rear_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            cur_reg, cur_next;
    logic [AW-1:0]            visited_reg, visited_next;
    logic signed [WORD_W-1:0] rdata_reg;

    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg;
    logic signed [WORD_W-1:0] out_data_reg;
    logic [SLOT_W-1:0]        out_slot_reg;
    logic                     out_last_reg;

    logic          empty, full, walk_last, out_free;
    logic [AW-1:0] push_slot;

    function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] idx);
        inc_idx = (idx == LAST_IDX) ? '0 : idx + AW'(1);
    endfunction

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CW'(DEPTH));
    assign walk_last = ((CW'(visited_reg) + CW'(1)) == count_reg);
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign push_slot = empty ? '0 : inc_idx(rear_reg);

    assign stat.command   = item_reg.command;
    assign stat.empty     = empty;
    assign stat.full      = full;
    assign stat.hit       = (rdata_reg == item_reg.match_value);
    assign stat.walk_last = walk_last;
    assign stat.out_free  = out_free;

    // Captured item (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            item_reg.command     <= command_t'(s_axis_tdata[1:0]);
            item_reg.value       <= s_axis_tdata[33:2];
            item_reg.match_value <= s_axis_tdata[65:34];
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.push_write)
            mem[push_slot] <= item_reg.value;
        else if (ctrl.repl_write)
            mem[cur_reg] <= item_reg.value;
        if (ctrl.rd_issue)
            rdata_reg <= mem[cur_reg];
    end

    // Ring indices and occupancy
    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        count_next = count_reg;
        if (ctrl.push_write)
        begin
            if (empty)
                front_next = '0;
            rear_next  = push_slot;
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.pop_commit)
        begin
            if (count_reg == CW'(1))
            begin
                front_next = '0;
                rear_next  = '0;
            end
            else
                front_next = inc_idx(front_reg);
            count_next = count_reg - CW'(1);
        end
    end

    // Walk pointer over the occupied entries
    always_comb
    begin
        cur_next     = cur_reg;
        visited_next = visited_reg;
        if (ctrl.walk_start)
        begin
            cur_next     = front_reg;
            visited_next = '0;
        end
        else if (ctrl.walk_next)
        begin
            cur_next     = inc_idx(cur_reg);
            visited_next = visited_reg + AW'(1);
        end
    end

    // Output register valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.emit)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            rear_reg      <= '0;
            count_reg     <= '0;
            cur_reg       <= '0;
            visited_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            rear_reg      <= rear_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            visited_reg   <= visited_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            out_data_reg <= '0;
            out_slot_reg <= '0;
            out_last_reg <= 1'b1;
            case (ctrl.emit_sel)
                EMIT_PUSH_OK:
                begin
                    out_status_reg <= ST_OK;
                    out_slot_reg   <= SLOT_W'(push_slot);
                end
                EMIT_FULL:     out_status_reg <= ST_FULL;
                EMIT_EMPTY:    out_status_reg <= ST_EMPTY;
                EMIT_NOTFOUND: out_status_reg <= ST_NOTFOUND;
                EMIT_POP:
                begin
                    out_status_reg <= ST_OK;
                    out_data_reg   <= rdata_reg;
                    out_slot_reg   <= SLOT_W'(cur_reg);
                end
                EMIT_REPLACE:
                begin
                    out_status_reg <= ST_OK;
                    out_slot_reg   <= SLOT_W'(cur_reg);
                end
                EMIT_DUMP:
                begin
                    out_status_reg <= ST_OK;
                    out_data_reg   <= rdata_reg;
                    out_slot_reg   <= SLOT_W'(cur_reg);
                    out_last_reg   <= walk_last;
                end
                default:       out_status_reg <= ST_NOTFOUND;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {3'b000, out_slot_reg, out_data_reg, out_status_reg};

endmodule

/* sv/cqr_ctrl.sv */
// Controller: sequences one command at a time over the datapath.
module cqr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  cqr_pkg::dp_stat_t stat,
    output cqr_pkg::dp_ctrl_t ctrl
);
    import cqr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_RD   = 4'b0100,
        S_CHK  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign s_axis_tready = (state_reg == S_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        ctrl.emit_sel = EMIT_PUSH_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    ctrl.load_item = 1'b1;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.command == CMD_PUSH)
                begin
                    if (stat.out_free)
                    begin
                        ctrl.emit = 1'b1;
                        if (stat.full)
                            ctrl.emit_sel = EMIT_FULL;
                        else
                        begin
                            ctrl.push_write = 1'b1;
                            ctrl.emit_sel   = EMIT_PUSH_OK;
                        end
                        state_next = S_IDLE;
                    end
                end
                else if (stat.empty)
                begin
                    if (stat.out_free)
                    begin
                        ctrl.emit     = 1'b1;
                        ctrl.emit_sel = EMIT_EMPTY;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    ctrl.walk_start = 1'b1;
                    state_next      = S_RD;
                end
            end
            S_RD:
            begin
                ctrl.rd_issue = 1'b1;
                state_next    = S_CHK;
            end
            S_CHK:
            begin
                case (stat.command)
                    CMD_POP:
                    begin
                        if (stat.out_free)
                        begin
                            ctrl.emit       = 1'b1;
                            ctrl.emit_sel   = EMIT_POP;
                            ctrl.pop_commit = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                    CMD_REPLACE:
                    begin
                        if (stat.hit)
                        begin
                            if (stat.out_free)
                            begin
                                ctrl.emit       = 1'b1;
                                ctrl.emit_sel   = EMIT_REPLACE;
                                ctrl.repl_write = 1'b1;
                                state_next      = S_IDLE;
                            end
                        end
                        else if (stat.walk_last)
                        begin
                            if (stat.out_free)
                            begin
                                ctrl.emit     = 1'b1;
                                ctrl.emit_sel = EMIT_NOTFOUND;
                                state_next    = S_IDLE;
                            end
                        end
                        else
                        begin
                            ctrl.walk_next = 1'b1;
                            state_next     = S_RD;
                        end
                    end
                    CMD_DUMP:
                    begin
                        if (stat.out_free)
                        begin
                            ctrl.emit     = 1'b1;
                            ctrl.emit_sel = EMIT_DUMP;
                            if (stat.walk_last)
                                state_next = S_IDLE;
                            else
                            begin
                                ctrl.walk_next = 1'b1;
                                state_next     = S_RD;
                            end
                        end
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* sv/circular_queue_with_replace.sv */
// Top level of the circular queue with replace: controller plus datapath.
//
//   Channel  Dir  Handshake                     Payload
//   s_axis   in   s_axis_tvalid/s_axis_tready   tdata: command, value, match_value
//   m_axis   out  m_axis_tvalid/m_axis_tready   tdata: status, data, slot; tlast: last
//
// Push, and any command on an empty queue, has its result loaded in S_EXEC.
// Pop passes S_EXEC, S_RD, S_CHK; replace repeats S_RD, S_CHK per entry visited; dump
// yields an item per S_RD/S_CHK pass: the entry memory has one registered read port.
// One command is in work at a time; the next is taken once the last result is loaded.
// Reset empties the queue at once; entry storage is not cleared.
// A held result stalls the walk; the output register takes a new item as the old is taken.
module circular_queue_with_replace #(
    parameter int DEPTH = cqr_pkg::DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [1:0] command, [33:2] value, [65:34] match_value, [71:66] zero
    input  logic [cqr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [1:0] status, [33:2] data, [36:34] slot, [39:37] zero
    output logic [cqr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast
);
    import cqr_pkg::*;

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    cqr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .ctrl          (ctrl)
    );

    cqr_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .ctrl          (ctrl),
        .stat          (stat)
    );

endmodule

/* test/circular_queue_with_replace_tb.sv */
// Self-checking testbench for the circular queue with replace: directed and random commands.
module circular_queue_with_replace_tb;
    import cqr_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;
    localparam int PAD_W       = IN_TDATA_W - CMD_W - 2 * WORD_W;

    typedef struct {
        status_t              status;
        logic [WORD_W-1:0]    data;
        logic [SLOT_W-1:0]    slot;
        logic                 last;
    } queue_result_t;

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tlast;

    // Shadow of the ring and the results still owed by the block
    logic [WORD_W-1:0]  ring_word [DEPTH];
    int                 head_slot   = 0;
    int                 tail_slot   = 0;
    bit                 ring_empty  = 1'b1;
    queue_result_t      owed_results [$];

    int errors      = 0;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    circular_queue_with_replace #(
        .DEPTH (DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic int ring_fill();
        if (ring_empty)
            return 0;
        return ((tail_slot + DEPTH - head_slot) % DEPTH) + 1;
    endfunction

    function automatic void owe(status_t st, logic [WORD_W-1:0] d, int s, bit l);
        queue_result_t r;
        r.status = st;
        r.data   = d;
        r.slot   = s[SLOT_W-1:0];
        r.last   = l;
        owed_results.push_back(r);
    endfunction

    // Advance the shadow queue by one command and record the results it owes
    function automatic void run_queue_command(command_t c, logic [WORD_W-1:0] v,
                                              logic [WORD_W-1:0] m);
        int  n;
        int  s;
        bit  found;
        n = ring_fill();
        if (c == CMD_PUSH)
        begin
            if (n >= DEPTH)
            begin
                owe(ST_FULL, '0, 0, 1'b1);
                return;
            end
            if (ring_empty)
            begin
                head_slot  = 0;
                tail_slot  = 0;
                ring_empty = 1'b0;
            end
            else
                tail_slot = (tail_slot + 1) % DEPTH;
            ring_word[tail_slot] = v;
            owe(ST_OK, '0, tail_slot, 1'b1);
            return;
        end
        if (n == 0)
        begin
            owe(ST_EMPTY, '0, 0, 1'b1);
            return;
        end
        s = head_slot;
        case (c)
            CMD_POP:
            begin
                owe(ST_OK, ring_word[s], s, 1'b1);
                if (n == 1)
                begin
                    ring_empty = 1'b1;
                    head_slot  = 0;
                    tail_slot  = 0;
                end
                else
                    head_slot = (head_slot + 1) % DEPTH;
            end
            CMD_REPLACE:
            begin
                found = 1'b0;
                for (int i = 0; i < n; i++)
                begin
                    if (!found && ring_word[s] == m)
                    begin
                        ring_word[s] = v;
                        owe(ST_OK, '0, s, 1'b1);
                        found = 1'b1;
                    end
                    s = (s + 1) % DEPTH;
                end
                if (!found)
                    owe(ST_NOTFOUND, '0, 0, 1'b1);
            end
            default:
            begin
                for (int i = 0; i < n; i++)
                begin
                    owe(ST_OK, ring_word[s], s, i == n - 1);
                    s = (s + 1) % DEPTH;
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch in %s at cycle %0d: got %0h, expected %0h",
                 what, cycle_count, got, want);
        errors++;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (owed_results.size() == 0)
                report_mismatch("unexpected item", m_axis_tdata, 0);
            else
            begin
                want = owed_results.pop_front();
                if (m_axis_tdata[1:0] != want.status)
                    report_mismatch("status", m_axis_tdata[1:0], want.status);
                if (m_axis_tdata[33:2] != want.data)
                    report_mismatch("data", m_axis_tdata[33:2], want.data);
                if (m_axis_tdata[36:34] != want.slot)
                    report_mismatch("slot", m_axis_tdata[36:34], want.slot);
                if (m_axis_tlast != want.last)
                    report_mismatch("last", m_axis_tlast, want.last);
            end
        end
    end

    // Offer one item, with random gaps ahead of it, and wait for acceptance
    task automatic send_item(command_t c, logic [WORD_W-1:0] v, logic [WORD_W-1:0] m);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, m, v, c};
        do
            @(posedge clk);
        while (!s_axis_tready);
        run_queue_command(c, v, m);
    endtask

    // Stop sending and wait until every owed result has arrived
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (owed_results.size() != 0);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0;
            4, 5:    return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    // Pop, replace and dump on an empty queue
    task automatic test_empty_queue();
        send_item(CMD_POP, 32'h1234_5678, 32'h0);
        send_item(CMD_REPLACE, 32'h0, 32'h0);
        send_item(CMD_DUMP, 32'hffff_ffff, 32'hffff_ffff);
        drain_results();
    endtask

    // Fill with extreme words, push once more when full, then dump it all
    task automatic test_fill_and_full();
        send_item(CMD_PUSH, 32'h8000_0000, 32'h0);
        send_item(CMD_PUSH, 32'h7fff_ffff, 32'h0);
        send_item(CMD_PUSH, 32'hffff_ffff, 32'h0);
        send_item(CMD_PUSH, 32'h0, 32'h0);
        send_item(CMD_PUSH, 32'haaaa_aaaa, 32'h0);
        send_item(CMD_PUSH, 32'h5555_5555, 32'h0);
        send_item(CMD_PUSH, 32'h1, 32'h0);
        send_item(CMD_PUSH, 32'hfffe_0001, 32'h0);
        send_item(CMD_PUSH, 32'hdead_beef, 32'h0);
        send_item(CMD_DUMP, 32'h0, 32'h0);
        drain_results();
    endtask

    // Replace hit and miss, wrap the rear round, first of two equal words wins
    task automatic test_replace_and_wrap();
        send_item(CMD_REPLACE, 32'h0bad_cafe, 32'h0);
        send_item(CMD_REPLACE, 32'h0, 32'h1357_9bdf);
        send_item(CMD_POP, 32'h0, 32'h0);
        send_item(CMD_PUSH, 32'hffff_ffff, 32'h0);
        send_item(CMD_REPLACE, 32'h2468_ace0, 32'hffff_ffff);
        send_item(CMD_DUMP, 32'h0, 32'h0);
        drain_results();
    endtask

    // Random commands; the trend swings between filling and draining the ring
    task automatic test_random_mix(int count, int tx_pct, int rx_pct);
        command_t           c;
        logic [WORD_W-1:0]  v;
        logic [WORD_W-1:0]  m;
        int                 r;
        bit                 filling;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        filling     = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            if (i % 12 == 0)
                filling = $urandom_range(0, 1);
            r = $urandom_range(0, 99);
            if (r < 45)
                c = filling ? CMD_PUSH : CMD_POP;
            else if (r < 65)
                c = filling ? CMD_POP : CMD_PUSH;
            else if (r < 85)
                c = CMD_REPLACE;
            else
                c = CMD_DUMP;
            v = pick_word();
            m = pick_word();
            // mostly search for a word that is really held
            if (c == CMD_REPLACE && !ring_empty && $urandom_range(0, 99) < 60)
                m = ring_word[(head_slot + $urandom_range(0, ring_fill() - 1)) % DEPTH];
            send_item(c, v, m);
        end
        drain_results();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_queue();
        test_fill_and_full();
        test_replace_and_wrap();
        test_random_mix(40, 15, 88);
        test_random_mix(40, 88, 15);
        test_random_mix(40, 0, 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && owed_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
